// File: sv/cbob_pkg.sv
// Shared types and constants for the cell bin overlap bucketing block.
package cbob_pkg;

	// request operation codes
	localparam logic [1:0] FUNC_PROC  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] CFG_BIN_W      = 3'd2;
	localparam logic [2:0] CFG_BIN_H      = 3'd3;
	localparam logic [2:0] CFG_INV_W      = 3'd4;
	localparam logic [2:0] CFG_INV_H      = 3'd5;
	localparam logic [2:0] CFG_SCALE      = 3'd6;
	localparam logic [2:0] CFG_SLAB_SIZE  = 3'd7;

	localparam int SLAB_SIZE_W = 19;

	// configuration reset values
	localparam logic [30:0] RST_BIN_SIZE  = 31'd65536;
	localparam logic [31:0] RST_INV       = 32'd65536;
	localparam logic [31:0] RST_SCALE     = 32'd65536;
	localparam logic [18:0] RST_SLAB_SIZE = 19'd4096;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SP_HI, ST_SP_LO, ST_SP_FIN, ST_CLAMP, ST_CHK,
		ST_X_MUL, ST_X_OVL, ST_Y_MUL, ST_Y_OVL,
		ST_W_A, ST_W_B, ST_W_C, ST_W_D, ST_W_E, ST_W_F, ST_W_G,
		ST_DV_INIT, ST_DV_STEP, ST_SLAB, ST_CNT_RD, ST_CNT_WR, ST_EMIT,
		ST_RD, ST_RD_EMIT, ST_CLR
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SP_HI, OP_SP_LO, OP_SP_FIN, OP_CLAMP,
		OP_X_MUL, OP_X_OVL, OP_Y_MUL, OP_Y_OVL,
		OP_W_A, OP_W_B, OP_W_C, OP_W_D, OP_W_E, OP_W_F, OP_W_G,
		OP_DIV_INIT, OP_DIV_STEP, OP_SLAB, OP_CNT_RD, OP_CNT_WR, OP_EMIT,
		OP_RD_SEL, OP_RD_EMIT, OP_CLEAR
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] ep;  // span endpoint: x low, x high, y low, y high
	} cmd_t;

	typedef struct packed {
		logic kc_zero;
		logic hc_zero;
		logic k_last;
		logic h_last;
		logic out_free;
	} sts_t;

endpackage

// File: sv/cbob_ctrl.sv
// Sequencer for the bin overlap bucketing datapath.
module cbob_ctrl #(
	parameter int SLAB_COUNT = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     func,
	output logic           in_ready,
	input  cbob_pkg::sts_t sts,
	output cbob_pkg::cmd_t cmd
);
	import cbob_pkg::*;

	localparam int CW    = (SLAB_COUNT > 1) ? $clog2(SLAB_COUNT) : 1;
	localparam int CNT_W = (CW > 4) ? $clog2(CW) : 2;

	ctrl_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd.op   = OP_NONE;
		cmd.ep   = cnt_q[1:0];
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					cnt_d  = '0;
					unique case (func)
						FUNC_PROC:  state_d = ST_SP_HI;
						FUNC_READ:  state_d = ST_RD;
						FUNC_CLEAR: state_d = ST_CLR;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_SP_HI: begin
				cmd.op  = OP_SP_HI;
				state_d = ST_SP_LO;
			end
			ST_SP_LO: begin
				cmd.op  = OP_SP_LO;
				state_d = ST_SP_FIN;
			end
			ST_SP_FIN: begin
				cmd.op = OP_SP_FIN;
				if (cnt_q[1:0] == 2'd3) begin
					state_d = ST_CLAMP;
				end else begin
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = ST_SP_HI;
				end
			end
			ST_CLAMP: begin
				cmd.op  = OP_CLAMP;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				state_d = (sts.kc_zero || sts.hc_zero) ? ST_IDLE : ST_X_MUL;
			end
			ST_X_MUL: begin
				cmd.op  = OP_X_MUL;
				state_d = ST_X_OVL;
			end
			ST_X_OVL: begin
				cmd.op  = OP_X_OVL;
				state_d = ST_Y_MUL;
			end
			ST_Y_MUL: begin
				cmd.op  = OP_Y_MUL;
				state_d = ST_Y_OVL;
			end
			ST_Y_OVL: begin
				cmd.op  = OP_Y_OVL;
				state_d = ST_W_A;
			end
			ST_W_A: begin
				cmd.op  = OP_W_A;
				state_d = ST_W_B;
			end
			ST_W_B: begin
				cmd.op  = OP_W_B;
				state_d = ST_W_C;
			end
			ST_W_C: begin
				cmd.op  = OP_W_C;
				state_d = ST_W_D;
			end
			ST_W_D: begin
				cmd.op  = OP_W_D;
				state_d = ST_W_E;
			end
			ST_W_E: begin
				cmd.op  = OP_W_E;
				state_d = ST_W_F;
			end
			ST_W_F: begin
				cmd.op  = OP_W_F;
				state_d = ST_W_G;
			end
			ST_W_G: begin
				cmd.op  = OP_W_G;
				state_d = ST_DV_INIT;
			end
			ST_DV_INIT: begin
				cmd.op  = OP_DIV_INIT;
				cnt_d   = '0;
				state_d = ST_DV_STEP;
			end
			ST_DV_STEP: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == CNT_W'(CW - 1)) begin
					state_d = ST_SLAB;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_SLAB: begin
				cmd.op  = OP_SLAB;
				state_d = ST_CNT_RD;
			end
			ST_CNT_RD: begin
				cmd.op  = OP_CNT_RD;
				state_d = ST_CNT_WR;
			end
			ST_CNT_WR: begin
				cmd.op  = OP_CNT_WR;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.op = OP_EMIT;
					priority if (!sts.h_last) state_d = ST_Y_MUL;
					else if (!sts.k_last)     state_d = ST_X_MUL;
					else                      state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.op  = OP_RD_SEL;
				state_d = ST_RD_EMIT;
			end
			ST_RD_EMIT: begin
				if (sts.out_free) begin
					cmd.op  = OP_RD_EMIT;
					state_d = ST_IDLE;
				end
			end
			ST_CLR: begin
				cmd.op  = OP_CLEAR;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: sv/cbob_dp.sv
// Datapath: span search, overlap and weight arithmetic, slab divider, counts and output register.
module cbob_dp #(
	parameter int BINS_X     = 512,
	parameter int BINS_Y     = 512,
	parameter int SLAB_COUNT = 64,
	parameter int MAX_SPAN   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [23:0]         cell_index,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  offset_x,
	input  logic signed [31:0]  offset_y,
	input  logic [30:0]         size_x,
	input  logic [30:0]         size_y,
	input  logic [23:0]         ratio,
	input  logic [5:0]          slab_select,
	input  cbob_pkg::cmd_t      cmd,
	output cbob_pkg::sts_t      sts,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [23:0]         cell_out,
	output logic signed [31:0]  weight,
	output logic [17:0]         bin_index,
	output logic [5:0]          slab,
	output logic [31:0]         slab_count,
	output logic                last
);
	import cbob_pkg::*;

	localparam int XIW = (BINS_X > 1) ? $clog2(BINS_X) : 1;
	localparam int YIW = (BINS_Y > 1) ? $clog2(BINS_Y) : 1;
	localparam int SW  = $clog2(MAX_SPAN + 1);
	localparam int BGW = (BINS_X * BINS_Y > 1) ? $clog2(BINS_X * BINS_Y) : 1;
	localparam int CW  = (SLAB_COUNT > 1) ? $clog2(SLAB_COUNT) : 1;
	localparam int DW  = ((BGW > SLAB_SIZE_W + CW) ? BGW : SLAB_SIZE_W + CW) + 1;
	localparam int RW  = 38;

	// overlap of [pl, ph) with the bin [org + prod, org + prod + bsz), saturated
	function automatic logic signed [31:0] ovl_sat(input logic signed [31:0] org,
			input logic [43:0] prod, input logic [30:0] bsz,
			input logic signed [33:0] pl, input logic signed [33:0] ph);
		logic signed [46:0] elo, ehi, top, bot, d;
		elo = 47'(org) + $signed(47'(prod));
		ehi = elo + $signed(47'(bsz));
		top = (47'(ph) < ehi) ? 47'(ph) : ehi;
		bot = (47'(pl) > elo) ? 47'(pl) : elo;
		d   = top - bot;
		if (d > 47'sh7FFFFFFF)
			return 32'sh7FFFFFFF;
		else if (d < -47'sh80000000)
			return -32'sh80000000;
		else
			return 32'(d);
	endfunction

	// configuration
	logic signed [31:0]     org_x_q, org_y_q;
	logic [30:0]            bw_q, bh_q;
	logic [31:0]            inv_w_q, inv_h_q, scale_q;
	logic [SLAB_SIZE_W-1:0] slab_size_q;

	// item
	logic [23:0]        cell_q, ratio_q;
	logic [5:0]         sel_q;
	logic signed [32:0] px0_q, py0_q;
	logic signed [33:0] xt_q, yt_q;

	// arithmetic
	logic [63:0]          mp_q;
	logic [65:0]          acc_q;
	logic [55:0]          a_q;
	logic [63:0]          b_q;
	logic signed [RW-1:0] raw_q [4];
	logic [XIW-1:0]       first_x_q;
	logic [YIW-1:0]       first_y_q;
	logic [SW-1:0]        kc_q, hc_q, k_q, h_q;
	logic signed [31:0]   ox_q, oy_q;
	logic                 wz_q, wn_q;
	logic [BGW-1:0]       bg_q;
	logic [DW-1:0]        rem_q, dsh_q;
	logic [CW-1:0]        dq_q, slab_q;
	logic                 ovf_q;

	// slab counts
	logic [31:0]           cnt_mem [SLAB_COUNT];
	logic [SLAB_COUNT-1:0] vld_q;
	logic [31:0]           rd_q;
	logic                  rd_vld_q;

	// output register
	logic               out_valid_q, o_last_q;
	logic [23:0]        o_cell_q;
	logic signed [31:0] o_weight_q;
	logic [17:0]        o_bin_q;
	logic [5:0]         o_slab_q;
	logic [31:0]        o_count_q;

	logic [31:0]            mul_a, mul_b;
	logic signed [33:0]     ep_v;
	logic signed [31:0]     org_v;
	logic [31:0]            inv_v;
	logic signed [34:0]     diff;
	logic [34:0]            mag;
	logic [52:0]            qsum;
	logic signed [RW-1:0]   qv, raw_v;
	logic signed [RW:0]     lo_c [2];
	logic [SW-1:0]          cnt_c [2];
	logic [XIW-1:0]         xi_c;
	logic [YIW-1:0]         yi_c;
	logic [31:0]            mx, my;
	logic signed [31:0]     weight_c;
	logic [SLAB_SIZE_W-1:0] dvs;
	logic                   ge;
	logic [CW-1:0]          rd_addr;
	logic                   sel_in;
	logic signed [32:0]     px0_c, py0_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q     <= '0;
			org_y_q     <= '0;
			bw_q        <= RST_BIN_SIZE;
			bh_q        <= RST_BIN_SIZE;
			inv_w_q     <= RST_INV;
			inv_h_q     <= RST_INV;
			scale_q     <= RST_SCALE;
			slab_size_q <= RST_SLAB_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:  org_x_q     <= cfg_data;
				CFG_ORIGIN_Y:  org_y_q     <= cfg_data;
				CFG_BIN_W:     bw_q        <= cfg_data[30:0];
				CFG_BIN_H:     bh_q        <= cfg_data[30:0];
				CFG_INV_W:     inv_w_q     <= cfg_data;
				CFG_INV_H:     inv_h_q     <= cfg_data;
				CFG_SCALE:     scale_q     <= cfg_data;
				CFG_SLAB_SIZE: slab_size_q <= cfg_data[SLAB_SIZE_W-1:0];
			endcase
		end
	end

	assign px0_c = 33'(pos_x) + 33'(offset_x);
	assign py0_c = 33'(pos_y) + 33'(offset_y);

	// span endpoint magnitude relative to the origin
	always_comb begin
		unique case (cmd.ep)
			2'd0: ep_v = 34'(px0_q);
			2'd1: ep_v = xt_q;
			2'd2: ep_v = 34'(py0_q);
			default: ep_v = yt_q;
		endcase
		org_v = cmd.ep[1] ? org_y_q : org_x_q;
		inv_v = cmd.ep[1] ? inv_h_q : inv_w_q;
		diff  = 35'(ep_v) - 35'(org_v);
		mag   = diff[34] ? 35'(-diff) : 35'(diff);
		qsum  = 53'(acc_q[51:0]) + 53'(mp_q[63:16]);
		qv    = RW'({1'b0, qsum[52:16]});
		raw_v = diff[34] ? -qv : qv;
	end

	// clamp both spans to the grid and to MAX_SPAN
	always_comb begin
		logic signed [RW:0] hi1, hic, nb, dc;
		for (int i = 0; i < 2; i++) begin
			nb       = (i == 0) ? (RW+1)'(BINS_X) : (RW+1)'(BINS_Y);
			lo_c[i]  = (raw_q[2*i] < 0) ? '0 : (RW+1)'(raw_q[2*i]);
			hi1      = (RW+1)'(raw_q[2*i+1]) + (RW+1)'(1);
			hic      = (hi1 > nb) ? nb : hi1;
			dc       = hic - lo_c[i];
			if (dc <= 0)
				cnt_c[i] = '0;
			else if (dc > (RW+1)'(MAX_SPAN))
				cnt_c[i] = SW'(MAX_SPAN);
			else
				cnt_c[i] = SW'(dc);
		end
	end

	assign xi_c = first_x_q + XIW'(k_q);
	assign yi_c = first_y_q + YIW'(h_q);
	assign mx   = ox_q[31] ? 32'(-ox_q) : 32'(ox_q);
	assign my   = oy_q[31] ? 32'(-oy_q) : 32'(oy_q);

	// one shared 32x32 multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_SP_HI: begin mul_a = 32'(mag[34:16]); mul_b = inv_v; end
			OP_SP_LO: begin mul_a = 32'(mag[15:0]);  mul_b = inv_v; end
			OP_X_MUL: begin mul_a = 32'(xi_c);       mul_b = 32'(bw_q); end
			OP_Y_MUL: begin mul_a = 32'(yi_c);       mul_b = 32'(bh_q); end
			OP_W_A:   begin mul_a = 32'(ratio_q);    mul_b = mx; end
			OP_W_B:   begin mul_a = my;              mul_b = scale_q; end
			OP_W_C:   begin mul_a = a_q[31:0];       mul_b = mp_q[31:0]; end
			OP_W_D:   begin mul_a = a_q[31:0];       mul_b = b_q[63:32]; end
			OP_W_E:   begin mul_a = 32'(a_q[55:32]); mul_b = b_q[31:0]; end
			OP_W_F:   begin mul_a = 32'(a_q[55:32]); mul_b = b_q[63:32]; end
			default: ;
		endcase
	end

	assign dvs     = (slab_size_q == '0) ? SLAB_SIZE_W'(1) : slab_size_q;
	assign ge      = rem_q >= dsh_q;
	assign rd_addr = (cmd.op == OP_RD_SEL) ? CW'(sel_q) : slab_q;
	assign sel_in  = {26'd0, sel_q} < SLAB_COUNT;

	// acc holds the rounded high word of the weight product, a magnitude
	always_comb begin
		if (wz_q)
			weight_c = '0;
		else if (!wn_q)
			weight_c = (acc_q > 66'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(acc_q[31:0]);
		else
			weight_c = (acc_q >= 66'h80000000) ? -32'sh80000000
				: $signed(32'd0 - acc_q[31:0]);
	end

	always_ff @(posedge clk) begin
		mp_q <= 64'(mul_a) * 64'(mul_b);
		unique case (cmd.op)
			OP_LOAD: begin
				cell_q  <= cell_index;
				ratio_q <= ratio;
				sel_q   <= slab_select;
				px0_q   <= px0_c;
				py0_q   <= py0_c;
				xt_q    <= 34'(px0_c) + $signed(34'(size_x));
				yt_q    <= 34'(py0_c) + $signed(34'(size_y));
			end
			OP_SP_LO:  acc_q <= 66'(mp_q);
			OP_SP_FIN: raw_q[cmd.ep] <= raw_v;
			OP_CLAMP: begin
				first_x_q <= XIW'(lo_c[0]);
				first_y_q <= YIW'(lo_c[1]);
				kc_q      <= cnt_c[0];
				hc_q      <= cnt_c[1];
				k_q       <= '0;
			end
			OP_X_OVL: begin
				ox_q <= ovl_sat(org_x_q, mp_q[43:0], bw_q, 34'(px0_q), xt_q);
				h_q  <= '0;
			end
			OP_Y_OVL: begin
				oy_q <= ovl_sat(org_y_q, mp_q[43:0], bh_q, 34'(py0_q), yt_q);
				bg_q <= BGW'(xi_c) * BGW'(BINS_Y) + BGW'(yi_c);
			end
			OP_W_A: begin
				wz_q <= (ox_q == 0) || (oy_q == 0);
				wn_q <= ox_q[31] ^ oy_q[31];
			end
			OP_W_B: a_q <= mp_q[55:0];
			OP_W_C: b_q <= mp_q;
			OP_W_D: acc_q <= 66'(mp_q) + {2'b0, 1'b1, 63'd0};
			OP_W_E: acc_q <= (acc_q >> 32) + 66'(mp_q);
			OP_W_F: acc_q <= acc_q + 66'(mp_q);
			OP_W_G: acc_q <= (acc_q >> 32) + 66'(mp_q);
			OP_DIV_INIT: begin
				rem_q <= DW'(bg_q);
				ovf_q <= DW'(bg_q) >= (DW'(dvs) << CW);
				dsh_q <= DW'(dvs) << (CW - 1);
				dq_q  <= '0;
			end
			OP_DIV_STEP: begin
				if (ge)
					rem_q <= rem_q - dsh_q;
				dq_q  <= CW'({dq_q, ge});
				dsh_q <= dsh_q >> 1;
			end
			OP_SLAB: begin
				slab_q <= (ovf_q || dq_q >= CW'(SLAB_COUNT - 1)) ? CW'(SLAB_COUNT - 1) : dq_q;
			end
			OP_EMIT: begin
				if (!sts.h_last)
					h_q <= h_q + SW'(1);
				else if (!sts.k_last)
					k_q <= k_q + SW'(1);
			end
			default: ;
		endcase
	end

	// count store, one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CNT_RD || cmd.op == OP_RD_SEL) begin
			rd_q     <= cnt_mem[rd_addr];
			rd_vld_q <= vld_q[rd_addr] && (cmd.op == OP_CNT_RD || sel_in);
		end
		if (cmd.op == OP_CNT_WR)
			cnt_mem[slab_q] <= (rd_vld_q ? rd_q : 32'd0) + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (cmd.op == OP_CLEAR)
			vld_q <= '0;
		else if (cmd.op == OP_CNT_WR)
			vld_q[slab_q] <= 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_EMIT || cmd.op == OP_RD_EMIT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			o_cell_q   <= cell_q;
			o_weight_q <= weight_c;
			o_bin_q    <= 18'(bg_q);
			o_slab_q   <= 6'(slab_q);
			o_count_q  <= '0;
			o_last_q   <= sts.k_last && sts.h_last;
		end else if (cmd.op == OP_RD_EMIT) begin
			o_cell_q   <= '0;
			o_weight_q <= '0;
			o_bin_q    <= '0;
			o_slab_q   <= sel_q;
			o_count_q  <= rd_vld_q ? rd_q : 32'd0;
			o_last_q   <= 1'b1;
		end
	end

	assign sts.kc_zero  = (kc_q == '0);
	assign sts.hc_zero  = (hc_q == '0);
	assign sts.k_last   = ((SW+1)'(k_q) + (SW+1)'(1)) == (SW+1)'(kc_q);
	assign sts.h_last   = ((SW+1)'(h_q) + (SW+1)'(1)) == (SW+1)'(hc_q);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign cell_out   = o_cell_q;
	assign weight     = o_weight_q;
	assign bin_index  = o_bin_q;
	assign slab       = o_slab_q;
	assign slab_count = o_count_q;
	assign last       = o_last_q;

endmodule

// File: sv/cell_bin_overlap_bucketing.sv
// Top level of the cell bin overlap bucketing block.
// One request is worked at a time. A process request (func 0) produces one record
// per covered bin, kc and hc being the clamped bin spans; its work is serialised on the
// single shared 32x32 multiplier that every span, overlap and weight product passes
// through and on the one-bit-per-cycle slab divider. A count read selects a slab and
// then emits its count; a clear resets the valid flags of all slab counts.
// The output register lets the next request be taken while the last result waits.
module cell_bin_overlap_bucketing #(
	parameter int BINS_X     = 512,
	parameter int BINS_Y     = 512,
	parameter int SLAB_COUNT = 64,
	parameter int MAX_SPAN   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [23:0]        cell_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic [30:0]        size_x,
	input  logic [30:0]        size_y,
	input  logic [23:0]        ratio,
	input  logic [5:0]         slab_select,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        cell_out,
	output logic signed [31:0] weight,
	output logic [17:0]        bin_index,
	output logic [5:0]         slab,
	output logic [31:0]        slab_count,
	output logic               last
);
	import cbob_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cbob_ctrl #(
		.SLAB_COUNT(SLAB_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbob_dp #(
		.BINS_X     (BINS_X),
		.BINS_Y     (BINS_Y),
		.SLAB_COUNT (SLAB_COUNT),
		.MAX_SPAN   (MAX_SPAN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cell_index  (cell_index),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.offset_x    (offset_x),
		.offset_y    (offset_y),
		.size_x      (size_x),
		.size_y      (size_y),
		.ratio       (ratio),
		.slab_select (slab_select),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.cell_out    (cell_out),
		.weight      (weight),
		.bin_index   (bin_index),
		.slab        (slab),
		.slab_count  (slab_count),
		.last        (last)
	);

	// a taken request with work to do keeps the input closed on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FUNC_PROC || func == FUNC_READ || func == FUNC_CLEAR)
		|=> !in_ready)
		else $error("input ready straight after taking a request");

	// only a count read carries a nonzero count, and it is a lone final result
	a_readout_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slab_count != 0
		|-> weight == 0 && bin_index == 0 && cell_out == 0 && last)
		else $error("count read result malformed");

endmodule
